// ===== hw/rtl/dfpa_pkg.sv =====
package dfpa_pkg;

    // Frame layout
    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [7:0] COMMAND_BYTE = 8'hC0;
    localparam logic [7:0] TAIL_BYTE    = 8'hAB;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int READ_W   = 16;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 8;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
    localparam logic [POS_W-1:0] POS_COMMAND  = 4'd1;
    localparam logic [POS_W-1:0] POS_FINE_LO  = 4'd2;
    localparam logic [POS_W-1:0] POS_FINE_HI  = 4'd3;
    localparam logic [POS_W-1:0] POS_COARSE_LO = 4'd4;
    localparam logic [POS_W-1:0] POS_COARSE_HI = 4'd5;
    localparam logic [POS_W-1:0] POS_SUM_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd8;
    localparam logic [POS_W-1:0] POS_TAIL     = 4'd9;

    typedef enum logic [1:0] {
        FS_GOOD      = 2'd0,
        FS_CHECKSUM  = 2'd1,
        FS_BAD_FRAME = 2'd2
    } t_frame_status;

    typedef enum logic [1:0] {
        AS_ALL_GOOD    = 2'd0,
        AS_SOME_FAILED = 2'd1,
        AS_ALL_FAILED  = 2'd2
    } t_avg_status;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE        = 5'b00001,
        S_FINE_GO     = 5'b00010,
        S_FINE_WAIT   = 5'b00100,
        S_COARSE_GO   = 5'b01000,
        S_COARSE_WAIT = 5'b10000
    } t_state;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        t_avg_status       average_status;
        logic [READ_W-1:0] avg_pm10_tenths;
        logic [READ_W-1:0] avg_pm25_tenths;
        logic              average_ready;
        t_frame_status     frame_status;
        logic [READ_W-1:0] pm10_tenths;
        logic [READ_W-1:0] pm25_tenths;
    } t_result;

    // Divider request from the sequencer
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== hw/rtl/dfpa_div.sv =====
module dfpa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dfpa_pkg::t_div_req                i_req,
    output logic                              o_done,
    output logic [dfpa_pkg::SUM_W-1:0]        o_quotient
);

    logic [dfpa_pkg::COUNT_W-1:0]   r_rem;
    logic [dfpa_pkg::SUM_W-1:0]     r_quo;
    logic [dfpa_pkg::COUNT_W-1:0]   r_divisor;
    logic [dfpa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [dfpa_pkg::COUNT_W:0]     trial;
    logic [dfpa_pkg::COUNT_W:0]     diff;
    logic                           fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[dfpa_pkg::SUM_W-1]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
    end

    // Control: load on start, count one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == dfpa_pkg::DIV_CNT_W'(dfpa_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[dfpa_pkg::COUNT_W-1:0] : trial[dfpa_pkg::COUNT_W-1:0];
            r_quo <= {r_quo[dfpa_pkg::SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/dust_frame_parser_averager_core.sv =====
// A frame's last byte gives its result word in the next cycle; when it closes an
// averaging window that holds a good frame, the word follows two 24-step passes
// of the shared divider.
// Throughput: one byte per cycle, except during those divider passes and while a
// frame's last byte waits for the previous result word to be taken.
// Reset: synchronous, active low; clears parser position, sums, counters and
// output valid, and sets average_count to 1.
module dust_frame_parser_averager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: average_count
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [15:0] pm25_tenths, [31:16] pm10_tenths,
                                        // [33:32] frame_status, [34] average_ready,
                                        // [50:35] avg_pm25_tenths,
                                        // [66:51] avg_pm10_tenths,
                                        // [68:67] average_status, [71:69] zero
);

    localparam int SW = dfpa_pkg::SUM_W;
    localparam int CW = dfpa_pkg::COUNT_W;
    localparam int RW = dfpa_pkg::READ_W;

    dfpa_pkg::t_state          r_state, n_state;
    logic [dfpa_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                r_chk_run, n_chk_run;
    logic [7:0]                r_cmd, n_cmd;
    logic [7:0]                r_chk, n_chk;
    logic [RW-1:0]             r_fine, n_fine;
    logic [RW-1:0]             r_coarse, n_coarse;
    logic [SW-1:0]             r_fine_sum, n_fine_sum;
    logic [SW-1:0]             r_coarse_sum, n_coarse_sum;
    logic [CW-1:0]             r_good, n_good;
    logic [CW-1:0]             r_att, n_att;
    logic [CW-1:0]             r_avg_count;
    logic                      r_out_valid, n_out_valid;
    dfpa_pkg::t_result         r_out, n_out;

    dfpa_pkg::t_div_req        div_req;
    logic                      div_done;
    logic [SW-1:0]             div_quo;

    logic                      in_acc;
    logic                      out_acc;
    logic [7:0]                b;
    dfpa_pkg::t_frame_status   fstat;
    logic [CW-1:0]             window;
    logic [CW-1:0]             att_inc;
    logic [CW-1:0]             good_inc;
    logic [SW-1:0]             fine_add;
    logic [SW-1:0]             coarse_add;

    assign b       = s_axis_tdata;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Take bytes only when idle; hold a frame's last byte while a result waits
    assign s_axis_tready = (r_state == dfpa_pkg::S_IDLE) &&
                           (!r_out_valid || (r_pos != dfpa_pkg::POS_TAIL));

    // Frame check and window update for the last byte
    always_comb begin
        if ((r_cmd != dfpa_pkg::COMMAND_BYTE) || (b != dfpa_pkg::TAIL_BYTE)) begin
            fstat = dfpa_pkg::FS_BAD_FRAME;
        end else if (r_chk_run != r_chk) begin
            fstat = dfpa_pkg::FS_CHECKSUM;
        end else begin
            fstat = dfpa_pkg::FS_GOOD;
        end
        fine_add   = r_fine_sum + SW'(r_fine);
        coarse_add = r_coarse_sum + SW'(r_coarse);
        good_inc   = r_good + 1'b1;
        att_inc    = r_att + 1'b1;
        window     = (r_avg_count == '0) ? CW'(1) : r_avg_count;
    end

    // Divider requests from the go states
    always_comb begin
        div_req.start    = (r_state == dfpa_pkg::S_FINE_GO) ||
                           (r_state == dfpa_pkg::S_COARSE_GO);
        div_req.dividend = (r_state == dfpa_pkg::S_COARSE_GO) ? r_coarse_sum : r_fine_sum;
        div_req.divisor  = r_good;
    end

    // Parser and sequencer
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_chk_run    = r_chk_run;
        n_cmd        = r_cmd;
        n_chk        = r_chk;
        n_fine       = r_fine;
        n_coarse     = r_coarse;
        n_fine_sum   = r_fine_sum;
        n_coarse_sum = r_coarse_sum;
        n_good       = r_good;
        n_att        = r_att;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dfpa_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((r_pos == dfpa_pkg::POS_HUNT) || (r_pos > dfpa_pkg::POS_TAIL)) begin
                        // hunt: drop everything but the header
                        n_pos = dfpa_pkg::POS_HUNT;
                        if (b == dfpa_pkg::HEADER_BYTE) begin
                            n_pos     = dfpa_pkg::POS_COMMAND;
                            n_chk_run = '0;
                        end
                    end else if (r_pos != dfpa_pkg::POS_TAIL) begin
                        // collect frame bytes
                        n_pos = r_pos + 1'b1;
                        if ((r_pos >= dfpa_pkg::POS_FINE_LO) &&
                            (r_pos <= dfpa_pkg::POS_SUM_LAST)) begin
                            n_chk_run = r_chk_run + b;
                        end
                        case (r_pos)
                            dfpa_pkg::POS_COMMAND:   n_cmd = b;
                            dfpa_pkg::POS_FINE_LO:   n_fine[7:0] = b;
                            dfpa_pkg::POS_FINE_HI:   n_fine[15:8] = b;
                            dfpa_pkg::POS_COARSE_LO: n_coarse[7:0] = b;
                            dfpa_pkg::POS_COARSE_HI: n_coarse[15:8] = b;
                            dfpa_pkg::POS_CHECK:     n_chk = b;
                            default: ;
                        endcase
                    end else begin
                        // tail byte: frame complete
                        n_pos = dfpa_pkg::POS_HUNT;
                        n_out.pad          = '0;
                        n_out.frame_status = fstat;
                        n_out.pm25_tenths  = '0;
                        n_out.pm10_tenths  = '0;
                        n_out.avg_pm25_tenths = '0;
                        n_out.avg_pm10_tenths = '0;
                        n_out.average_status  = dfpa_pkg::AS_ALL_GOOD;
                        n_att = att_inc;
                        if (fstat == dfpa_pkg::FS_GOOD) begin
                            n_out.pm25_tenths = r_fine;
                            n_out.pm10_tenths = r_coarse;
                            n_fine_sum   = fine_add;
                            n_coarse_sum = coarse_add;
                            n_good       = good_inc;
                        end
                        n_out.average_ready = (att_inc >= window);
                        if (att_inc < window) begin
                            n_out_valid = 1'b1;
                        end else if (n_good == '0) begin
                            // all attempts failed: zero averages
                            n_out.average_status = dfpa_pkg::AS_ALL_FAILED;
                            n_out_valid  = 1'b1;
                            n_fine_sum   = '0;
                            n_coarse_sum = '0;
                            n_good       = '0;
                            n_att        = '0;
                        end else begin
                            n_out.average_status = (n_good == att_inc) ?
                                dfpa_pkg::AS_ALL_GOOD : dfpa_pkg::AS_SOME_FAILED;
                            n_state = dfpa_pkg::S_FINE_GO;
                        end
                    end
                end
            end
            dfpa_pkg::S_FINE_GO: begin
                n_state = dfpa_pkg::S_FINE_WAIT;
            end
            dfpa_pkg::S_FINE_WAIT: begin
                if (div_done) begin
                    n_out.avg_pm25_tenths = div_quo[RW-1:0];
                    n_state = dfpa_pkg::S_COARSE_GO;
                end
            end
            dfpa_pkg::S_COARSE_GO: begin
                n_state = dfpa_pkg::S_COARSE_WAIT;
            end
            dfpa_pkg::S_COARSE_WAIT: begin
                if (div_done) begin
                    // publish result and clear the window
                    n_out.avg_pm10_tenths = div_quo[RW-1:0];
                    n_out_valid  = 1'b1;
                    n_fine_sum   = '0;
                    n_coarse_sum = '0;
                    n_good       = '0;
                    n_att        = '0;
                    n_state      = dfpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dfpa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dfpa_pkg::S_IDLE;
            r_pos        <= dfpa_pkg::POS_HUNT;
            r_chk_run    <= '0;
            r_fine_sum   <= '0;
            r_coarse_sum <= '0;
            r_good       <= '0;
            r_att        <= '0;
            r_out_valid  <= 1'b0;
            r_avg_count  <= CW'(1);
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_chk_run    <= n_chk_run;
            r_fine_sum   <= n_fine_sum;
            r_coarse_sum <= n_coarse_sum;
            r_good       <= n_good;
            r_att        <= n_att;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_avg_count <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_chk    <= n_chk;
        r_fine   <= n_fine;
        r_coarse <= n_coarse;
        r_out    <= n_out;
    end

    dfpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Bytes are only taken while the sequencer is idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == dfpa_pkg::S_IDLE))
        else $error("input ready outside idle");

    // Divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == dfpa_pkg::S_FINE_WAIT) ||
                      (r_state == dfpa_pkg::S_COARSE_WAIT)))
        else $error("divider done outside a wait state");

    // A failed frame carries zero readings
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.frame_status != dfpa_pkg::FS_GOOD)) |->
        ((r_out.pm25_tenths == '0) && (r_out.pm10_tenths == '0)))
        else $error("failed frame with nonzero readings");

    // Window counters clear when a window result is published
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out.average_ready) |->
        ((r_att == '0) && (r_good == '0)))
        else $error("window counters not cleared");

    // Parser position never leaves the frame range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= dfpa_pkg::POS_TAIL)
        else $error("parser position out of range");

endmodule

// ===== tb/sv/dust_frame_result_checker.sv =====
module dust_frame_result_checker
    import dfpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,   // t_result layout, pm25_tenths in the low bits
    output int          o_error_count,
    output int          o_words_pending
);

    // Shadow copy of the parser and window state
    logic [POS_W-1:0]   parse_pos;
    logic [7:0]         frame_bytes [10];
    logic [7:0]         payload_sum;
    logic [SUM_W-1:0]   fine_total;
    logic [SUM_W-1:0]   coarse_total;
    logic [COUNT_W-1:0] good_count;
    logic [COUNT_W-1:0] attempt_count;
    logic [COUNT_W-1:0] window_len;

    t_result expected_words [$];
    t_result got_word;
    t_result want_word;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        o_error_count++;
    endtask

    // Advance the shadow parser by one byte; queue a result word on the tenth byte
    task automatic predict_byte(input logic [7:0] rx);
        t_result            res;
        logic [COUNT_W-1:0] window;
        res = '0;
        if (parse_pos == POS_HUNT || parse_pos > POS_TAIL) begin
            parse_pos = POS_HUNT;
            if (rx == HEADER_BYTE) begin
                frame_bytes[0] = rx;
                payload_sum = '0;
                parse_pos = POS_COMMAND;
            end
            return;
        end
        frame_bytes[parse_pos] = rx;
        if (parse_pos >= POS_FINE_LO && parse_pos <= POS_SUM_LAST) begin
            payload_sum = payload_sum + rx;
        end
        if (parse_pos != POS_TAIL) begin
            parse_pos = parse_pos + 1'b1;
            return;
        end

        // Frame complete: classify it
        parse_pos = POS_HUNT;
        if (frame_bytes[POS_COMMAND] != COMMAND_BYTE || frame_bytes[POS_TAIL] != TAIL_BYTE) begin
            res.frame_status = FS_BAD_FRAME;
        end else if (payload_sum != frame_bytes[POS_CHECK]) begin
            res.frame_status = FS_CHECKSUM;
        end else begin
            res.frame_status = FS_GOOD;
            res.pm25_tenths = {frame_bytes[POS_FINE_HI], frame_bytes[POS_FINE_LO]};
            res.pm10_tenths = {frame_bytes[POS_COARSE_HI], frame_bytes[POS_COARSE_LO]};
            fine_total = fine_total + SUM_W'(res.pm25_tenths);
            coarse_total = coarse_total + SUM_W'(res.pm10_tenths);
            good_count = good_count + 1'b1;
        end
        attempt_count = attempt_count + 1'b1;

        // Close the window once enough attempts are in; a zero length acts as one
        window = (window_len == '0) ? 8'd1 : window_len;
        if (attempt_count >= window) begin
            res.average_ready = 1'b1;
            if (good_count == '0) begin
                res.average_status = AS_ALL_FAILED;
            end else begin
                res.avg_pm25_tenths = 16'(fine_total / SUM_W'(good_count));
                res.avg_pm10_tenths = 16'(coarse_total / SUM_W'(good_count));
                res.average_status = (good_count == attempt_count) ? AS_ALL_GOOD
                                                                   : AS_SOME_FAILED;
            end
            fine_total = '0;
            coarse_total = '0;
            good_count = '0;
            attempt_count = '0;
        end
        expected_words.push_back(res);
    endtask

    // Check output words, then track config writes and input words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_pos = POS_HUNT;
            payload_sum = '0;
            fine_total = '0;
            coarse_total = '0;
            good_count = '0;
            attempt_count = '0;
            window_len = 8'd1;
            o_error_count = 0;
            expected_words.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_word = t_result'(m_axis_tdata);
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none expected", m_axis_tdata));
                end else begin
                    want_word = expected_words.pop_front();
                    if (got_word.pm25_tenths != want_word.pm25_tenths)
                        report_mismatch($sformatf("pm25_tenths %0d, want %0d",
                            got_word.pm25_tenths, want_word.pm25_tenths));
                    if (got_word.pm10_tenths != want_word.pm10_tenths)
                        report_mismatch($sformatf("pm10_tenths %0d, want %0d",
                            got_word.pm10_tenths, want_word.pm10_tenths));
                    if (got_word.frame_status != want_word.frame_status)
                        report_mismatch($sformatf("frame_status %0d, want %0d",
                            got_word.frame_status, want_word.frame_status));
                    if (got_word.average_ready != want_word.average_ready)
                        report_mismatch($sformatf("average_ready %0d, want %0d",
                            got_word.average_ready, want_word.average_ready));
                    if (got_word.avg_pm25_tenths != want_word.avg_pm25_tenths)
                        report_mismatch($sformatf("avg_pm25_tenths %0d, want %0d",
                            got_word.avg_pm25_tenths, want_word.avg_pm25_tenths));
                    if (got_word.avg_pm10_tenths != want_word.avg_pm10_tenths)
                        report_mismatch($sformatf("avg_pm10_tenths %0d, want %0d",
                            got_word.avg_pm10_tenths, want_word.avg_pm10_tenths));
                    if (got_word.average_status != want_word.average_status)
                        report_mismatch($sformatf("average_status %0d, want %0d",
                            got_word.average_status, want_word.average_status));
                    if (got_word.pad != '0)
                        report_mismatch($sformatf("pad bits %b, want zero", got_word.pad));
                end
            end
            if (i_cfg_we) begin
                window_len = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata);
            end
        end
        o_words_pending <= expected_words.size();
    end

endmodule

// ===== tb/sv/dust_frame_parser_averager_core_tb.sv =====
module dust_frame_parser_averager_core_tb;
    import dfpa_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASES           = 8;
    localparam int FRAMES_PER_PHASE = 13;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;
    int error_count;
    int words_pending;

    dust_frame_parser_averager_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dust_frame_result_checker u_result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .o_error_count   (error_count),
        .o_words_pending (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        m_axis_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dust_frame_parser_averager_core_tb: done, errors");
            $finish;
        end
    end

    // Offer one word, after a random gap, and hold it until accepted
    task automatic send_byte(input logic [7:0] value);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drain outstanding results, let the parser settle, then write the window length
    task automatic settle_and_set_window(input logic [7:0] len);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Send a frame with chosen readings and optional corruption
    task automatic send_fixed_frame(input logic [7:0] cmd, input logic [15:0] fine,
                                    input logic [15:0] coarse, input logic [7:0] sum_flip,
                                    input logic [7:0] tail);
        logic [7:0] spare_a;
        logic [7:0] spare_b;
        logic [7:0] sum;
        spare_a = 8'($urandom());
        spare_b = 8'($urandom());
        sum = fine[7:0] + fine[15:8] + coarse[7:0] + coarse[15:8] + spare_a + spare_b;
        send_byte(HEADER_BYTE);
        send_byte(cmd);
        send_byte(fine[7:0]);
        send_byte(fine[15:8]);
        send_byte(coarse[7:0]);
        send_byte(coarse[15:8]);
        send_byte(spare_a);
        send_byte(spare_b);
        send_byte(sum ^ sum_flip);
        send_byte(tail);
    endtask

    // Mostly well-formed frames with random payload, some broken or cut short, some noise
    task automatic send_random_frame();
        logic [7:0] frame [10];
        logic [7:0] sum;
        int         kind;
        int         len;
        int         pick;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom()));
        end
        frame[0] = HEADER_BYTE;
        frame[1] = COMMAND_BYTE;
        sum = '0;
        for (int i = 2; i < 8; i++) begin
            pick = $urandom_range(7);
            frame[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
            sum = sum + frame[i];
        end
        frame[8] = sum;
        frame[9] = TAIL_BYTE;
        len = 10;
        kind = $urandom_range(99);
        if (kind >= 96) begin
            len = $urandom_range(9, 1);
        end else if (kind >= 93) begin
            frame[1] = frame[1] ^ 8'($urandom_range(255, 1));
            frame[8] = frame[8] ^ 8'($urandom_range(255, 1));
        end else if (kind >= 88) begin
            frame[9] = frame[9] ^ 8'($urandom_range(255, 1));
        end else if (kind >= 83) begin
            frame[1] = frame[1] ^ 8'($urandom_range(255, 1));
        end else if (kind >= 75) begin
            frame[8] = frame[8] ^ 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < len; i++) begin
            send_byte(frame[i]);
        end
    endtask

    initial begin
        logic [7:0] windows     [PHASES];
        int         sender_pcts [PHASES];
        int         stall_pcts  [PHASES];
        windows     = '{8'd1, 8'd5, 8'd255, 8'd3, 8'd2, 8'd0, 8'd0, 8'd0};
        sender_pcts = '{0, 69, 0, 35, 0, 69, 0, 35};
        stall_pcts  = '{0, 0, 69, 35, 0, 0, 69, 35};
        windows[5]  = 8'($urandom_range(16, 1));
        windows[6]  = 8'($urandom());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Window of three: junk while hunting, maximal readings, bad checksum,
        // then everything bad at once
        settle_and_set_window(8'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(TAIL_BYTE);
        send_byte(COMMAND_BYTE);
        send_fixed_frame(COMMAND_BYTE, 16'hFFFF, 16'hFFFF, 8'h00, TAIL_BYTE);
        send_fixed_frame(COMMAND_BYTE, 16'h1234, 16'h00FF, 8'h01, TAIL_BYTE);
        send_fixed_frame(8'h3F, 16'h5A5A, 16'hA5A5, 8'h80, 8'h54);

        // Zero-length window acts as one: all-failed windows, then a zero reading
        settle_and_set_window(8'd0);
        send_fixed_frame(COMMAND_BYTE, 16'h8001, 16'h7FFE, 8'h00, HEADER_BYTE);
        send_fixed_frame(8'hC1, 16'h0100, 16'h0080, 8'h00, TAIL_BYTE);
        send_fixed_frame(COMMAND_BYTE, 16'h0000, 16'h0000, 8'h00, TAIL_BYTE);

        // Random phases across window lengths and idle patterns
        for (int p = 0; p < PHASES; p++) begin
            settle_and_set_window(windows[p]);
            sender_idle_pct    = sender_pcts[p];
            receiver_stall_pct = stall_pcts[p];
            repeat (FRAMES_PER_PHASE) send_random_frame();
        end

        // Drain and give the verdict
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (error_count == 0) begin
            $display("dust_frame_parser_averager_core_tb: done, clean");
        end else begin
            $display("dust_frame_parser_averager_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dfpa_pkg.sv
hw/rtl/dfpa_div.sv
hw/rtl/dust_frame_parser_averager_core.sv
tb/sv/dust_frame_result_checker.sv
tb/sv/dust_frame_parser_averager_core_tb.sv
